// ===== src/art_pkg.sv =====
`timescale 1ns / 1ps
// Package for the aging route table: table geometry, command and status codes,
// and the stored route record. Used by aging_route_table.
package art_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [31:0] TTL_RESET  = 32'd6000;
    localparam logic [7:0]  HOPS_RESET = 8'd16;

    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_PURGE  = 2'd2;
    localparam logic [1:0] CMD_DROP   = 2'd3;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_EVICTED   = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;
    localparam logic [2:0] ST_PURGED    = 3'd6;

    localparam logic CFG_TTL  = 1'b0;
    localparam logic CFG_HOPS = 1'b1;

    typedef struct packed {
        logic [63:0] dest;
        logic        family;
        logic [31:0] ipv4;
        logic [63:0] v6_high;
        logic [63:0] v6_low;
        logic [15:0] port;
        logic [7:0]  hops;
        logic [7:0]  metric;
        logic [31:0] seq;
        logic [31:0] age;
    } entry_t;
endpackage

// ===== src/aging_route_table.sv =====
`timescale 1ns / 1ps
// Aging distance-vector route table: sixteen routes in one synchronous memory.
// Depends on art_pkg.
//
// Usage: one command beat enters on in_valid/in_ready; exactly one result beat
// leaves on out_valid/out_ready. Configuration (TTL, max hops) is written on
// cfg_we with cfg_index and cfg_data; the user must do so only while the block
// is idle, which the block itself does not enforce.
// Every command sweeps all sixteen entries through the memory read port, one
// entry a cycle, then passes through the decision and write-back state and the
// state that loads the result register, from which the result beat is offered.
// The memory read port during the sweep sets the command rate; a new command
// is accepted only once the block is back in idle.
// The result sits in an output register, so the next command is accepted
// while a result waits; a stalled receiver only holds the finishing step.
// Reset clears the per-entry valid flags, the route count, the sequence
// counter and restores TTL 6000 and max hops 16; memory contents are left
// as they are, since an entry is only matched while its valid flag is set.
module aging_route_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [63:0]            dest_key,
    input  logic [31:0]            now_ticks,
    input  logic                   hop_family,
    input  logic [31:0]            hop_ipv4,
    input  logic [63:0]            hop_v6_high,
    input  logic [63:0]            hop_v6_low,
    input  logic                   v6_present,
    input  logic [15:0]            hop_port,
    input  logic [7:0]             hop_count,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [3:0]             slot,
    output logic                   out_family,
    output logic [31:0]            out_ipv4,
    output logic [63:0]            out_v6_high,
    output logic [63:0]            out_v6_low,
    output logic [15:0]            out_port,
    output logic [7:0]             out_hops,
    output logic [7:0]             out_metric,
    output logic [31:0]            out_sequence,
    output logic [4:0]             valid_routes,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data
);
    import art_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t             state_reg;
    logic [31:0]        ttl_reg;
    logic [7:0]         max_hops_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [31:0]        seq_reg;

    // Captured command.
    logic [1:0]  cmd_reg;
    logic [63:0] key_reg;
    logic [31:0] now_reg;
    logic        fam_reg;
    logic [31:0] ip4_reg;
    logic [63:0] v6h_reg;
    logic [63:0] v6l_reg;
    logic        v6p_reg;
    logic [15:0] port_reg;
    logic [7:0]  hops_reg;

    // Sweep control.
    logic [CNT_W-1:0] rd_idx_reg;
    logic             ev_valid_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    entry_t           rd_data_reg;

    // Sweep results.
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    entry_t           hit_rec_reg;
    logic [31:0]      oldest_reg;
    logic [IDX_W-1:0] oldest_idx_reg;
    logic [8:0]       best_reg;

    logic [2:0]       res_status_reg;
    logic [IDX_W-1:0] res_slot_reg;

    logic             out_valid_reg;

    entry_t mem [ENTRIES];

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    logic             free_any;
    logic [IDX_W-1:0] first_free_slot;
    logic [7:0]       new_metric;
    logic             overwrite;
    logic [2:0]       upd_status;
    logic [IDX_W-1:0] upd_slot;
    logic [31:0]      seq_inc;

    logic [31:0]      ev_age;
    logic             ev_live;
    logic             ev_stale;
    logic             ev_key_eq;
    logic             ev_hop_eq;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        free_any = 1'b0;
        first_free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                first_free_slot = IDX_W'(i);
            end
        end
    end

    assign new_metric = (hops_reg == 8'd0) ? 8'd1 : hops_reg;
    assign seq_inc    = seq_reg + 32'd1;
    assign overwrite  = (new_metric <= hit_rec_reg.metric) ||
                        ((now_reg - hit_rec_reg.age) > (ttl_reg >> 1));

    // Decision and write-back record for an update.
    always_comb
    begin
        mem_wdata = hit_rec_reg;
        if (hit_reg)
        begin
            upd_slot = hit_idx_reg;
            if (overwrite)
            begin
                upd_status        = ST_UPDATED;
                mem_wdata.family  = fam_reg;
                mem_wdata.ipv4    = ip4_reg;
                if (v6p_reg)
                begin
                    mem_wdata.v6_high = v6h_reg;
                    mem_wdata.v6_low  = v6l_reg;
                end
                mem_wdata.port    = port_reg;
                mem_wdata.hops    = hops_reg;
                mem_wdata.metric  = new_metric;
                mem_wdata.seq     = seq_inc;
            end
            else
            begin
                upd_status = ST_REFRESHED;
            end
        end
        else
        begin
            upd_slot   = free_any ? first_free_slot : oldest_idx_reg;
            upd_status = free_any ? ST_INSERTED : ST_EVICTED;
            mem_wdata.dest    = key_reg;
            mem_wdata.family  = fam_reg;
            mem_wdata.ipv4    = ip4_reg;
            mem_wdata.v6_high = v6p_reg ? v6h_reg : 64'd0;
            mem_wdata.v6_low  = v6p_reg ? v6l_reg : 64'd0;
            mem_wdata.port    = port_reg;
            mem_wdata.hops    = hops_reg;
            mem_wdata.metric  = new_metric;
            mem_wdata.seq     = seq_inc;
        end
        mem_wdata.age = now_reg;
    end

    assign mem_we    = (state_reg == S_WRITE) && (cmd_reg == CMD_UPDATE);
    assign mem_waddr = upd_slot;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    // Per-entry evaluation of the word read in the previous cycle.
    assign ev_age    = now_reg - rd_data_reg.age;
    assign ev_live   = ev_valid_reg && valid_reg[ev_idx_reg];
    assign ev_stale  = ev_age > ttl_reg;
    assign ev_key_eq = (rd_data_reg.dest == key_reg);
    assign ev_hop_eq = (rd_data_reg.family == fam_reg) && (rd_data_reg.port == port_reg) &&
                       (fam_reg ? ((rd_data_reg.v6_high == v6h_reg) &&
                                   (rd_data_reg.v6_low == v6l_reg))
                                : (rd_data_reg.ipv4 == ip4_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ttl_reg       <= TTL_RESET;
            max_hops_reg  <= HOPS_RESET;
            valid_reg     <= '0;
            total_reg     <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TTL)
                begin
                    ttl_reg <= cfg_data;
                end
                else
                begin
                    max_hops_reg <= cfg_data[7:0];
                end
            end

            // The finishing step owns out_valid_reg while it is active.
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            ev_valid_reg <= (state_reg == S_SCAN) && (rd_idx_reg < CNT_W'(ENTRIES));

            unique case (state_reg)
                S_IDLE:
                begin
                    rd_idx_reg <= '0;
                    if (in_valid)
                    begin
                        cmd_reg        <= cmd;
                        key_reg        <= dest_key;
                        now_reg        <= now_ticks;
                        fam_reg        <= hop_family;
                        ip4_reg        <= hop_ipv4;
                        v6h_reg        <= hop_v6_high;
                        v6l_reg        <= hop_v6_low;
                        v6p_reg        <= v6_present;
                        port_reg       <= hop_port;
                        hops_reg       <= hop_count;
                        hit_reg        <= 1'b0;
                        hit_idx_reg    <= '0;
                        oldest_reg     <= '0;
                        oldest_idx_reg <= '0;
                        best_reg       <= {1'b0, max_hops_reg} + 9'd1;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (rd_idx_reg < CNT_W'(ENTRIES))
                    begin
                        ev_idx_reg   <= rd_idx_reg[IDX_W-1:0];
                        rd_idx_reg   <= rd_idx_reg + CNT_W'(1);
                    end
                    if (ev_valid_reg)
                    begin
                        if (ev_age > oldest_reg)
                        begin
                            oldest_reg     <= ev_age;
                            oldest_idx_reg <= ev_idx_reg;
                        end
                        case (cmd_reg) inside
                            CMD_UPDATE:
                            begin
                                if (ev_live && ev_key_eq && !hit_reg)
                                begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= ev_idx_reg;
                                    hit_rec_reg <= rd_data_reg;
                                end
                            end
                            CMD_LOOKUP, CMD_PURGE:
                            begin
                                if (ev_live && ev_stale)
                                begin
                                    valid_reg[ev_idx_reg] <= 1'b0;
                                    total_reg <= total_reg - CNT_W'(1);
                                end
                                else if (ev_live && ev_key_eq &&
                                         ({1'b0, rd_data_reg.metric} < best_reg))
                                begin
                                    best_reg    <= {1'b0, rd_data_reg.metric};
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= ev_idx_reg;
                                    hit_rec_reg <= rd_data_reg;
                                end
                            end
                            default:
                            begin
                                if (ev_live && ev_hop_eq)
                                begin
                                    valid_reg[ev_idx_reg] <= 1'b0;
                                    total_reg <= total_reg - CNT_W'(1);
                                end
                            end
                        endcase
                        if (ev_idx_reg == IDX_W'(ENTRIES - 1))
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    case (cmd_reg)
                        CMD_UPDATE:
                        begin
                            res_status_reg <= upd_status;
                            res_slot_reg   <= upd_slot;
                            if (upd_status != ST_REFRESHED)
                            begin
                                seq_reg <= seq_inc;
                            end
                            if (!hit_reg)
                            begin
                                valid_reg[upd_slot] <= 1'b1;
                                if (free_any)
                                begin
                                    total_reg <= total_reg + CNT_W'(1);
                                end
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            res_status_reg <= hit_reg ? ST_FOUND : ST_NONE;
                            res_slot_reg   <= hit_reg ? hit_idx_reg : '0;
                        end
                        default:
                        begin
                            res_status_reg <= ST_PURGED;
                            res_slot_reg   <= '0;
                        end
                    endcase
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status        <= res_status_reg;
                        slot          <= 4'(res_slot_reg);
                        valid_routes  <= 5'(total_reg);
                        if (res_status_reg == ST_FOUND)
                        begin
                            out_family   <= hit_rec_reg.family;
                            out_ipv4     <= hit_rec_reg.ipv4;
                            out_v6_high  <= hit_rec_reg.v6_high;
                            out_v6_low   <= hit_rec_reg.v6_low;
                            out_port     <= hit_rec_reg.port;
                            out_hops     <= hit_rec_reg.hops;
                            out_metric   <= hit_rec_reg.metric;
                            out_sequence <= hit_rec_reg.seq;
                        end
                        else
                        begin
                            out_family   <= 1'b0;
                            out_ipv4     <= '0;
                            out_v6_high  <= '0;
                            out_v6_low   <= '0;
                            out_port     <= '0;
                            out_hops     <= '0;
                            out_metric   <= '0;
                            out_sequence <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
